// ===== design/tasi_pkg.sv =====
// Package for the three-address slot interpreter.
// Holds the command codes, divider request/response types and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tasi_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned SLOT_FIELD_W = 4;
   localparam int unsigned SLOT_FIELD_N = 1 << SLOT_FIELD_W;
   localparam int unsigned FUNC_W      = 8;
   localparam int unsigned DIV_STEPS   = DATA_W;
   localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [FUNC_W-1:0] PRINT_FUNC = FUNC_W'(1);

   typedef enum logic [3:0] {
      ACT_NOP   = 4'd0,
      ACT_ALLOC = 4'd1,
      ACT_LET   = 4'd2,
      ACT_ADD   = 4'd3,
      ACT_SUB   = 4'd4,
      ACT_MUL   = 4'd5,
      ACT_DIV   = 4'd6,
      ACT_MOD   = 4'd7,
      ACT_CALL  = 4'd8
   } action_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
      logic [DATA_W-1:0] remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== design/tasi_slot_ram.sv =====
// Variable slot store: one write port, two registered read ports.
// Per-entry valid bits make unwritten slots read as zero after reset.
// Depends on tasi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tasi_slot_ram
   import tasi_pkg::*;
#(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_a_addr,
   input  wire logic [AW-1:0]     rd_b_addr,
   output      logic [DATA_W-1:0] rd_a_data,
   output      logic [DATA_W-1:0] rd_b_data,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] slot_mem_ff [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;
   logic              rd_a_vld_ff;
   logic              rd_b_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= slot_mem_ff[rd_a_addr];
         rd_b_ff <= slot_mem_ff[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         rd_a_vld_ff <= 1'b0;
         rd_b_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_a_vld_ff <= vld_ff[rd_a_addr];
            rd_b_vld_ff <= vld_ff[rd_b_addr];
         end
      end
   end

   assign rd_a_data = rd_a_vld_ff ? rd_a_ff : '0;
   assign rd_b_data = rd_b_vld_ff ? rd_b_ff : '0;

endmodule

`default_nettype wire

// ===== design/tasi_divider.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Takes magnitudes; sign handling is left to the caller.
// Depends on tasi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tasi_divider
   import tasi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output      div_rsp_type div_rsp
);

   logic [DATA_W-1:0]    rem_ff,  rem_in;
   logic [DATA_W-1:0]    quo_ff,  quo_in;
   logic [DATA_W-1:0]    dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DATA_W:0]      shifted;
   logic [DATA_W:0]      diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
         end else begin
            rem_in = shifted[DATA_W-1:0];
         end
         quo_in = {quo_ff[DATA_W-2:0], ~diff[DATA_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (div_req.start) begin
         dvs_ff <= div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== design/three_address_slot_interpreter_unit.sv =====
// Three-address slot interpreter: one command per request against a store of
// 32-bit variable slots. Depends on tasi_pkg, tasi_slot_ram and tasi_divider.
//
// Request channel (req_*): req_valid / req_stall, accepted when valid and not
// stalled. Carries action, destination/left/right slot, literal and function id.
// Response channel (rsp_*): one response per request, rsp_valid / rsp_stall.
// Fields: printed flag, printed value (zero unless printed), divide fault.
//
// One request at a time. Non-divide commands pass through the execute and done
// states before the response. div and mod with a non-zero divisor run in the
// divide state on the shared one-bit-per-cycle divider. A zero divisor faults
// without starting the divider.
// Slot indices are taken modulo SLOT_COUNT; slot reads come from a two-read
// port store with a registered read.
//
// Reset clears all slots to zero at once (per-slot valid bits) and drops
// rsp_valid; a request may be accepted in the cycle after reset.
// The response is held in an output register; while the receiver stalls, one
// further request may be accepted and run, and it waits before writing its
// slot and loading the output register until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module three_address_slot_interpreter_unit
   import tasi_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [3:0]               req_action,
   input  wire logic [SLOT_FIELD_W-1:0]  req_dest_slot,
   input  wire logic [SLOT_FIELD_W-1:0]  req_left_slot,
   input  wire logic [SLOT_FIELD_W-1:0]  req_right_slot,
   input  wire logic signed [DATA_W-1:0] req_literal_value,
   input  wire logic [FUNC_W-1:0]        req_function_id,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic                     rsp_printed,
   output      logic signed [DATA_W-1:0] rsp_printed_value,
   output      logic                     rsp_divide_fault
);

   localparam int unsigned DEPTH = (SLOT_COUNT < SLOT_FIELD_N) ? SLOT_COUNT : SLOT_FIELD_N;
   localparam int unsigned AW    = $clog2(DEPTH);

   function automatic logic [SLOT_FIELD_N*AW-1:0] build_map();
      logic [SLOT_FIELD_N*AW-1:0] m;
      m = '0;
      for (int i = 0; i < SLOT_FIELD_N; i++) begin
         m[i*AW +: AW] = AW'(i % SLOT_COUNT);
      end
      return m;
   endfunction

   localparam logic [SLOT_FIELD_N*AW-1:0] SLOT_MAP = build_map();

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_DONE = 5'b01000,
      ST_SPARE = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [3:0]        act_ff;
   logic [AW-1:0]     dst_ff;
   logic [DATA_W-1:0] lit_ff;
   logic [FUNC_W-1:0] func_ff;
   logic [DATA_W-1:0] res_ff,   res_in;
   logic              wen_ff,   wen_in;
   logic              fault_ff, fault_in;
   logic              prt_ff,   prt_in;
   logic [DATA_W-1:0] pval_ff,  pval_in;
   logic              qneg_ff,  qneg_in;
   logic              rneg_ff,  rneg_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_prt_ff;
   logic [DATA_W-1:0] rsp_pval_ff;
   logic              rsp_fault_ff;

   logic              req_take;
   logic              out_load;
   logic [AW-1:0]     rd_a_addr;
   logic [AW-1:0]     rd_b_addr;
   logic [AW-1:0]     req_dst_idx;
   logic [DATA_W-1:0] opa;
   logic [DATA_W-1:0] opb;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign out_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rd_a_addr   = SLOT_MAP[req_left_slot*AW +: AW];
   assign rd_b_addr   = SLOT_MAP[req_right_slot*AW +: AW];
   assign req_dst_idx = SLOT_MAP[req_dest_slot*AW +: AW];

   tasi_slot_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_slot_ram (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_take),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (opa),
      .rd_b_data (opb),
      .wr_en     (out_load && wen_ff),
      .wr_addr   (dst_ff),
      .wr_data   (res_ff)
   );

   tasi_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in         = state_ff;
      res_in           = res_ff;
      wen_in           = wen_ff;
      fault_in         = fault_ff;
      prt_in           = prt_ff;
      pval_in          = pval_ff;
      qneg_in          = qneg_ff;
      rneg_in          = rneg_ff;
      div_req.start    = 1'b0;
      div_req.dividend = opa[DATA_W-1] ? (~opa + 1'b1) : opa;
      div_req.divisor  = opb[DATA_W-1] ? (~opb + 1'b1) : opb;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               wen_in   = 1'b0;
               fault_in = 1'b0;
               prt_in   = 1'b0;
               pval_in  = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (act_ff)
               ACT_LET: begin
                  res_in = lit_ff;
                  wen_in = 1'b1;
               end
               ACT_ADD: begin
                  res_in = opa + opb;
                  wen_in = 1'b1;
               end
               ACT_SUB: begin
                  res_in = opa - opb;
                  wen_in = 1'b1;
               end
               ACT_MUL: begin
                  res_in = opa * opb;
                  wen_in = 1'b1;
               end
               ACT_DIV, ACT_MOD: begin
                  if (opb == '0) begin
                     fault_in = 1'b1;
                  end else begin
                     div_req.start = 1'b1;
                     qneg_in       = opa[DATA_W-1] ^ opb[DATA_W-1];
                     rneg_in       = opa[DATA_W-1];
                     state_in      = ST_DIV;
                  end
               end
               ACT_CALL: begin
                  if (func_ff == PRINT_FUNC) begin
                     prt_in  = 1'b1;
                     pval_in = opa;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (act_ff == ACT_DIV) begin
                  res_in = qneg_ff ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
               end else begin
                  res_in = rneg_ff ? (~div_rsp.remainder + 1'b1) : div_rsp.remainder;
               end
               wen_in   = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff  <= req_action;
         dst_ff  <= req_dst_idx;
         lit_ff  <= req_literal_value;
         func_ff <= req_function_id;
      end
      res_ff   <= res_in;
      wen_ff   <= wen_in;
      fault_ff <= fault_in;
      prt_ff   <= prt_in;
      pval_ff  <= pval_in;
      qneg_ff  <= qneg_in;
      rneg_ff  <= rneg_in;
      if (out_load) begin
         rsp_prt_ff   <= prt_ff;
         rsp_pval_ff  <= pval_ff;
         rsp_fault_ff <= fault_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_printed       = rsp_prt_ff;
   assign rsp_printed_value = rsp_pval_ff;
   assign rsp_divide_fault  = rsp_fault_ff;

`ifndef SYNTHESIS
   a_req_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted but unit not busy next cycle");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_print_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_printed |-> rsp_printed_value == '0)
      else $error("printed value non-zero without print");

   a_fault_no_print: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_printed && rsp_divide_fault))
      else $error("fault and print in the same response");
`endif

endmodule

`default_nettype wire
